// File: rtl/pid_pkg.sv
// Shared constants, codes and widths for the priority interrupt dispatcher.
package pid_pkg;

    localparam int TIME_BITS_DEF = 64;

    localparam int IN_W  = 112;
    localparam int OUT_W = 72;
    localparam int CFG_W = 12;
    localparam int CFG_AW = 2;

    localparam int QUO_W = 30;
    localparam int DVS_W = 18;
    localparam logic [QUO_W-1:0] NS_PER_SEC   = 30'd1000000000;
    localparam logic [QUO_W-1:0] VSYNC_PERIOD = NS_PER_SEC / 60;

    localparam logic [CFG_AW-1:0] REG_TIMER_HZ    = 2'd0;
    localparam logic [CFG_AW-1:0] REG_IRQ_ENABLES = 2'd1;
    localparam logic [CFG_AW-1:0] REG_VECTOR_BASE = 2'd2;
    localparam logic [CFG_AW-1:0] REG_FRAME_LINES = 2'd3;

    localparam int EN_UART_BIT  = 7;
    localparam int EN_KEY_BIT   = 6;
    localparam int EN_VSYNC_BIT = 5;
    localparam int EN_HSYNC_BIT = 4;
    localparam int GIE_BIT      = 7;

    localparam logic [6:0] IRQ_NONE  = 7'h00;
    localparam logic [6:0] IRQ_TIMER = 7'h10;
    localparam logic [6:0] IRQ_KEY   = 7'h11;
    localparam logic [6:0] IRQ_UART  = 7'h12;
    localparam logic [6:0] IRQ_VSYNC = 7'h13;
    localparam logic [6:0] IRQ_HSYNC = 7'h14;

    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_WRITE = 2'd1;
    localparam logic [1:0] ACC_READ  = 2'd2;

    localparam logic [15:0] VEC_BASE_DEF  = 16'hFF00;
    localparam logic [11:0] LINES_DEF     = 12'd256;
    localparam logic [2:0]  LAST_ITEM     = 3'd4;

endpackage

// File: rtl/pid_div.sv
// Restoring divider: one quotient bit a cycle of one second in ns by a period divisor.
module pid_div
    import pid_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             run_reg,  run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [DVS_W-1:0] rem_reg,  rem_next;
    logic [QUO_W-1:0] quo_reg,  quo_next;
    logic [DVS_W-1:0] dvs_reg,  dvs_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fit;

    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fit   = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = NS_PER_SEC;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = fit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/priority_interrupt_dispatcher.sv
// Top level of the priority interrupt dispatcher: sequencer, timing state and result transfers.
// A check is taken when s_tready is high, which happens only while the block is idle. With
// interrupts disabled or no source due, the block returns to idle and sends nothing. A taken
// interrupt sends five transfers (three stack writes, two vector reads), the fifth with
// m_tlast. The timer and hsync periods come from one shared restoring divider that produces
// one quotient bit a cycle; a check that reaches hsync with the timer on runs two divisions,
// first the timer period and then the hsync period.
module priority_interrupt_dispatcher
    import pid_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    // now_ns[63:0], status[71:64], stack_ptr[87:72], pc[103:88], key_pending[104],
    // uart_pending[105], display_present[106], zero fill above
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // taken[0], irq_id[7:1], address[23:8], data[31:24], new_status[39:32],
    // new_stack_ptr[55:40], render_valid[56], render_line[68:57], zero fill above
    output logic [OUT_W-1:0]  m_tdata,
    // access[1:0]
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TDIV = 3'd1;
    localparam logic [2:0] S_TCMP = 3'd2;
    localparam logic [2:0] S_SEL  = 3'd3;
    localparam logic [2:0] S_HDIV = 3'd4;
    localparam logic [2:0] S_HCMP = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    localparam int PAD_W = TIME_BITS - QUO_W;

    logic [2:0]           state_reg, state_next;
    logic [2:0]           idx_reg,   idx_next;
    logic [7:0]           timer_hz_reg;
    logic [7:0]           irq_en_reg;
    logic [7:0]           vec_base_reg;
    logic [11:0]          lines_cfg_reg;
    logic [TIME_BITS-1:0] last_t_reg, last_t_next;
    logic [TIME_BITS-1:0] last_v_reg, last_v_next;
    logic [TIME_BITS-1:0] last_h_reg, last_h_next;
    logic                 vflag_reg,  vflag_next;
    logic [11:0]          scan_reg,   scan_next;
    logic [6:0]           id_reg,     id_next;
    logic                 rv_reg,     rv_next;
    logic [11:0]          rl_reg,     rl_next;

    logic [TIME_BITS-1:0] now_reg;
    logic [7:0]           status_reg;
    logic [15:0]          sp_reg;
    logic [15:0]          pc_reg;
    logic                 key_reg;
    logic                 uart_reg;
    logic                 disp_reg;

    logic                 s_xfer;
    logic                 m_xfer;
    logic                 div_start;
    logic [DVS_W-1:0]     div_divisor;
    logic                 div_done;
    logic [QUO_W-1:0]     div_quo;
    logic [TIME_BITS-1:0] period_ext;
    logic                 t_hit;
    logic                 v_hit;
    logic                 h_hit;
    logic [11:0]          lines;
    logic [DVS_W-1:0]     h_divisor;
    logic [12:0]          scan_inc;
    logic [15:0]          vec_base;
    logic [15:0]          vec_addr;
    logic [15:0]          item_addr;
    logic [7:0]           item_data;
    logic [1:0]           item_acc;
    logic [7:0]           new_status;
    logic [15:0]          new_sp;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == S_EMIT);
    assign m_xfer   = m_tvalid && m_tready;

    assign period_ext = {{PAD_W{1'b0}}, div_quo};
    assign t_hit = (now_reg - last_t_reg) >= period_ext;
    assign h_hit = (now_reg - last_h_reg) >= period_ext;
    assign v_hit = (now_reg - last_v_reg) >= {{PAD_W{1'b0}}, VSYNC_PERIOD};

    assign lines     = (lines_cfg_reg == '0) ? LINES_DEF : lines_cfg_reg;
    assign h_divisor = {lines, 6'd0} - {4'd0, lines, 2'd0};
    assign scan_inc  = {1'b0, scan_reg} + 13'd1;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        last_t_next = last_t_reg;
        last_v_next = last_v_reg;
        last_h_next = last_h_reg;
        vflag_next  = vflag_reg;
        scan_next   = scan_reg;
        id_next     = id_reg;
        rv_next     = rv_reg;
        rl_next     = rl_reg;
        div_start   = 1'b0;
        div_divisor = {{(DVS_W-8){1'b0}}, timer_hz_reg};
        case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                rv_next  = 1'b0;
                rl_next  = '0;
                id_next  = IRQ_NONE;
                if (s_xfer && s_tdata[64 + GIE_BIT])
                begin
                    if (timer_hz_reg != '0)
                    begin
                        div_start  = 1'b1;
                        state_next = S_TDIV;
                    end
                    else
                    begin
                        state_next = S_SEL;
                    end
                end
            end
            S_TDIV:
            begin
                if (div_done)
                    state_next = S_TCMP;
            end
            S_TCMP:
            begin
                if (t_hit)
                begin
                    last_t_next = now_reg;
                    id_next     = IRQ_TIMER;
                    state_next  = S_EMIT;
                end
                else
                begin
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                state_next = S_EMIT;
                if (irq_en_reg[EN_KEY_BIT] && key_reg)
                begin
                    id_next = IRQ_KEY;
                end
                else if (irq_en_reg[EN_UART_BIT] && uart_reg)
                begin
                    id_next = IRQ_UART;
                end
                else if (irq_en_reg[EN_VSYNC_BIT] && vflag_reg)
                begin
                    vflag_next = 1'b0;
                    id_next    = IRQ_VSYNC;
                end
                else if (irq_en_reg[EN_VSYNC_BIT] && !disp_reg && v_hit)
                begin
                    last_v_next = now_reg;
                    id_next     = IRQ_VSYNC;
                end
                else if (irq_en_reg[EN_HSYNC_BIT])
                begin
                    div_start   = 1'b1;
                    div_divisor = h_divisor;
                    state_next  = S_HDIV;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_HDIV:
            begin
                if (div_done)
                    state_next = S_HCMP;
            end
            S_HCMP:
            begin
                if (h_hit)
                begin
                    last_h_next = now_reg;
                    rv_next     = 1'b1;
                    rl_next     = scan_reg;
                    id_next     = IRQ_HSYNC;
                    if (scan_inc >= {1'b0, lines})
                    begin
                        scan_next  = '0;
                        vflag_next = 1'b1;
                    end
                    else
                    begin
                        scan_next = scan_inc[11:0];
                    end
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (m_xfer)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_ITEM)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            timer_hz_reg  <= '0;
            irq_en_reg    <= '0;
            vec_base_reg  <= '0;
            lines_cfg_reg <= '0;
            last_t_reg    <= '0;
            last_v_reg    <= '0;
            last_h_reg    <= '0;
            vflag_reg     <= 1'b0;
            scan_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            last_t_reg <= last_t_next;
            last_v_reg <= last_v_next;
            last_h_reg <= last_h_next;
            vflag_reg  <= vflag_next;
            scan_reg   <= scan_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_TIMER_HZ:    timer_hz_reg  <= cfg_wdata[7:0];
                    REG_IRQ_ENABLES: irq_en_reg    <= cfg_wdata[7:0];
                    REG_VECTOR_BASE: vec_base_reg  <= cfg_wdata[7:0];
                    REG_FRAME_LINES: lines_cfg_reg <= cfg_wdata[11:0];
                    default:         lines_cfg_reg <= lines_cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
        rv_reg <= rv_next;
        rl_reg <= rl_next;
        if (s_xfer)
        begin
            now_reg    <= s_tdata[TIME_BITS-1:0];
            status_reg <= s_tdata[71:64];
            sp_reg     <= s_tdata[87:72];
            pc_reg     <= s_tdata[103:88];
            key_reg    <= s_tdata[104];
            uart_reg   <= s_tdata[105];
            disp_reg   <= s_tdata[106];
        end
    end

    pid_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign vec_base   = (vec_base_reg == '0) ? VEC_BASE_DEF : {vec_base_reg[7:1], 9'd0};
    assign vec_addr   = vec_base + {8'd0, id_reg, 1'b0};
    assign new_status = {1'b0, status_reg[6:0]};
    assign new_sp     = sp_reg - 16'd3;

    always_comb
    begin
        case (idx_reg)
            3'd0:
            begin
                item_acc  = ACC_WRITE;
                item_addr = sp_reg;
                item_data = pc_reg[15:8];
            end
            3'd1:
            begin
                item_acc  = ACC_WRITE;
                item_addr = sp_reg - 16'd1;
                item_data = pc_reg[7:0];
            end
            3'd2:
            begin
                item_acc  = ACC_WRITE;
                item_addr = sp_reg - 16'd2;
                item_data = status_reg;
            end
            3'd3:
            begin
                item_acc  = ACC_READ;
                item_addr = vec_addr;
                item_data = '0;
            end
            3'd4:
            begin
                item_acc  = ACC_READ;
                item_addr = vec_addr + 16'd1;
                item_data = '0;
            end
            default:
            begin
                item_acc  = ACC_NONE;
                item_addr = '0;
                item_data = '0;
            end
        endcase
    end

    assign m_tdata = {3'd0, rl_reg, rv_reg, new_sp, new_status, item_data, item_addr,
                      id_reg, 1'b1};
    assign m_tuser = item_acc;
    assign m_tlast = (idx_reg == LAST_ITEM);

endmodule

// File: rtl/pid_chk.sv
// Port checker for the priority interrupt dispatcher and its bind to the top level.
module pid_chk
    import pid_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic [1:0]       m_tuser,
    input logic             m_tlast
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while results are pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("result burst broken before last");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result after last transfer");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("result right after input transfer");

endmodule

bind priority_interrupt_dispatcher pid_chk u_pid_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: test/tb_priority_interrupt_dispatcher.sv
`timescale 1ns / 100ps
// Testbench for the priority interrupt dispatcher: directed table, random checks, scoreboard.
module tb_priority_interrupt_dispatcher;
    import pid_pkg::*;

    localparam logic [63:0] SEC_NS = 64'd1000000000;
    localparam logic [63:0] VSYNC_NS = SEC_NS / 64'd60;
    localparam logic [6:0] PREDICT_ID = 7'h7F;
    localparam logic [2:0] F_KEY = 3'b001;
    localparam logic [2:0] F_UART = 3'b010;
    localparam logic [2:0] F_DISP = 3'b100;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 46;
    localparam int MAX_PRINTS = 40;

    typedef struct {
        logic [63:0] now;
        logic [7:0]  status;
        logic [15:0] sp;
        logic [15:0] pc;
        logic        key;
        logic        uart;
        logic        display;
    } check_t;

    typedef struct {
        logic [6:0]  irq_id;
        logic [1:0]  access;
        logic [15:0] address;
        logic [7:0]  data;
        logic [7:0]  new_status;
        logic [15:0] new_sp;
        logic        render_valid;
        logic [11:0] render_line;
        logic        last;
    } xfer_t;

    typedef struct {
        bit                is_cfg;
        logic [CFG_AW-1:0] reg_idx;
        logic [CFG_W-1:0]  reg_val;
        check_t            chk;
        logic [6:0]        want_id;
        logic [15:0]       want_vec;
    } row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;

    logic [7:0]  timer_hz_r = '0;
    logic [7:0]  enables_r = '0;
    logic [7:0]  vbase_r = '0;
    logic [11:0] lines_r = '0;
    logic [63:0] t_timer = '0;
    logic [63:0] t_vsync = '0;
    logic [63:0] t_hsync = '0;
    logic        vflag_r = 1'b0;
    logic [11:0] scanline_r = '0;

    xfer_t       pending_xfers[$];
    row_t        dir_rows[$];
    int          mismatches = 0;
    int          checks_sent = 0;
    int          xfers_seen = 0;
    int          holds_done = 0;
    int          fired[5] = '{0, 0, 0, 0, 0};
    bit          hold_req = 1'b0;
    int          tx_max_gap = 16;
    int          rx_max_stall = 16;
    logic [63:0] clock_ns = '0;

    priority_interrupt_dispatcher u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic log_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] mismatch in %s: got 'h%0h, want 'h%0h", $time, what, got, want);
    endtask

    task automatic match_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            log_mismatch(what, got, want);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_TIMER_HZ:    timer_hz_r = val[7:0];
            REG_IRQ_ENABLES: enables_r = val[7:0];
            REG_VECTOR_BASE: vbase_r = val[7:0];
            REG_FRAME_LINES: lines_r = val;
            default:         ;
        endcase
    endtask

    task automatic dispatch_check(input check_t c, input logic [6:0] want_id,
                                  input logic [15:0] want_vec);
        logic [6:0]  id;
        logic        rv;
        logic [11:0] rl;
        logic [11:0] lines;
        logic [12:0] nxt;
        logic [15:0] vec;
        xfer_t       x;
        id = IRQ_NONE;
        rv = 1'b0;
        rl = '0;
        if (c.status[GIE_BIT])
        begin
            if (timer_hz_r != 0 && c.now - t_timer >= SEC_NS / timer_hz_r)
            begin
                t_timer = c.now;
                id = IRQ_TIMER;
            end
            else if (enables_r[EN_KEY_BIT] && c.key)
                id = IRQ_KEY;
            else if (enables_r[EN_UART_BIT] && c.uart)
                id = IRQ_UART;
            else if (enables_r[EN_VSYNC_BIT] && vflag_r)
            begin
                vflag_r = 1'b0;
                id = IRQ_VSYNC;
            end
            else if (enables_r[EN_VSYNC_BIT] && !c.display && c.now - t_vsync >= VSYNC_NS)
            begin
                t_vsync = c.now;
                id = IRQ_VSYNC;
            end
            else if (enables_r[EN_HSYNC_BIT])
            begin
                lines = (lines_r == 0) ? LINES_DEF : lines_r;
                if (c.now - t_hsync >= SEC_NS / (64'd60 * lines))
                begin
                    t_hsync = c.now;
                    rv = 1'b1;
                    rl = scanline_r;
                    nxt = {1'b0, scanline_r} + 13'd1;
                    if (nxt >= {1'b0, lines})
                    begin
                        nxt = '0;
                        vflag_r = 1'b1;
                    end
                    scanline_r = nxt[11:0];
                    id = IRQ_HSYNC;
                end
            end
        end
        vec = ((vbase_r == 0) ? VEC_BASE_DEF : {vbase_r & 8'hFE, 8'h00}) + {8'h00, id, 1'b0};
        if (want_id != PREDICT_ID)
        begin
            id = want_id;
            vec = want_vec;
        end
        if (id != IRQ_NONE)
        begin
            fired[id - IRQ_TIMER]++;
            x.irq_id = id;
            x.new_status = {1'b0, c.status[6:0]};
            x.new_sp = c.sp - 16'd3;
            x.render_valid = rv;
            x.render_line = rl;
            x.last = 1'b0;
            x.access = ACC_WRITE;
            x.address = c.sp;
            x.data = c.pc[15:8];
            pending_xfers.push_back(x);
            x.address = c.sp - 16'd1;
            x.data = c.pc[7:0];
            pending_xfers.push_back(x);
            x.address = c.sp - 16'd2;
            x.data = c.status;
            pending_xfers.push_back(x);
            x.access = ACC_READ;
            x.address = vec;
            x.data = '0;
            pending_xfers.push_back(x);
            x.address = vec + 16'd1;
            x.last = 1'b1;
            pending_xfers.push_back(x);
        end
    endtask

    task automatic send_check(input check_t c, input logic [6:0] want_id,
                              input logic [15:0] want_vec);
        int gap;
        gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {5'b0, c.display, c.uart, c.key, c.pc, c.sp, c.status, c.now};
        do @(posedge clk); while (!s_tready);
        dispatch_check(c, want_id, want_vec);
        checks_sent++;
        @(negedge clk);
    endtask

    task automatic settle_block;
        s_tvalid = 1'b0;
        while (pending_xfers.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic add_cfg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
        row_t r;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        dir_rows.push_back(r);
    endtask

    task automatic add_chk(input logic [63:0] now, input logic [7:0] st, input logic [15:0] sp,
                           input logic [15:0] pc, input logic [2:0] flags,
                           input logic [6:0] want_id, input logic [15:0] want_vec);
        row_t r;
        r.is_cfg = 1'b0;
        r.chk.now = now;
        r.chk.status = st;
        r.chk.sp = sp;
        r.chk.pc = pc;
        r.chk.key = flags[0];
        r.chk.uart = flags[1];
        r.chk.display = flags[2];
        r.want_id = want_id;
        r.want_vec = want_vec;
        dir_rows.push_back(r);
    endtask

    function automatic check_t random_check();
        check_t c;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick >= 95)
            clock_ns = {$urandom, $urandom};
        else if (pick >= 80)
            clock_ns += $urandom_range(0, 2000000000);
        else if (pick >= 50)
            clock_ns += $urandom_range(0, 20000000);
        else if (pick >= 10)
            clock_ns += $urandom_range(0, 70000);
        c.now = clock_ns;
        c.status = $urandom_range(0, 255);
        if ($urandom_range(0, 3) != 0)
            c.status[GIE_BIT] = 1'b1;
        c.sp = $urandom_range(0, 65535);
        c.pc = $urandom_range(0, 65535);
        c.key = ($urandom_range(0, 99) < 15);
        c.uart = ($urandom_range(0, 99) < 15);
        c.display = $urandom_range(0, 1);
        return c;
    endfunction

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("tb_priority_interrupt_dispatcher: done, errors");
                $finish;
            end
        end
    end

    initial
    begin : result_side
        xfer_t            e;
        int               stall;
        logic [OUT_W-1:0] d;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req && holds_done == 0)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            stall = (rx_max_stall == 0) ? 0 : $urandom_range(0, rx_max_stall);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            d = m_tdata;
            xfers_seen++;
            if (pending_xfers.size() == 0)
                log_mismatch("transfer with nothing expected, irq_id", d[7:1], IRQ_NONE);
            else
            begin
                e = pending_xfers.pop_front();
                match_field("taken", d[0], 1'b1);
                match_field("irq_id", d[7:1], e.irq_id);
                match_field("access", m_tuser, e.access);
                match_field("address", d[23:8], e.address);
                match_field("data", d[31:24], e.data);
                match_field("new_status", d[39:32], e.new_status);
                match_field("new_stack_ptr", d[55:40], e.new_sp);
                match_field("render_valid", d[56], e.render_valid);
                match_field("render_line", d[68:57], e.render_line);
                match_field("tlast", m_tlast, e.last);
                match_field("zero fill", d[OUT_W-1:69], '0);
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0]  hz;
        logic [7:0]  en;
        logic [7:0]  vb;
        logic [11:0] fl;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        add_chk(64'd0, 8'h00, 16'h1234, 16'h5678, F_KEY | F_UART, IRQ_NONE, '0);
        add_chk(64'd0, 8'h80, 16'h1234, 16'h5678, F_KEY | F_UART, IRQ_NONE, '0);
        add_cfg(REG_IRQ_ENABLES, 12'h0F0);
        add_chk(64'd0, 8'hFF, 16'h0000, 16'hFFFF, F_KEY | F_UART, IRQ_KEY, 16'hFF22);
        add_chk(64'd0, 8'h80, 16'h0002, 16'h0000, F_UART, IRQ_UART, 16'hFF24);
        add_chk(64'd65104, 8'hA5, 16'hFFFF, 16'h8001, F_DISP, PREDICT_ID, '0);
        add_chk(64'd16666666, 8'hC3, 16'h8000, 16'h7FFE, 3'b000, IRQ_VSYNC, 16'hFF26);
        // shrink the frame below the current scanline: draw it, wrap, flag vsync
        add_cfg(REG_FRAME_LINES, 12'd1);
        add_chk(64'd40000000, 8'h80, 16'h4000, 16'h1111, F_DISP, PREDICT_ID, '0);
        add_chk(64'd40000000, 8'h80, 16'h4000, 16'h1111, F_DISP, IRQ_VSYNC, 16'hFF26);
        add_cfg(REG_TIMER_HZ, 12'd255);
        add_chk(64'hFFFF_FFFF_FFFF_FFFF, 8'h80, 16'hFFFF, 16'hFFFF, 3'b000, IRQ_TIMER, 16'hFF20);
        // elapsed time wraps through zero and lands exactly on the period
        add_chk(64'd3921567, 8'h80, 16'h0001, 16'h0000, 3'b000, IRQ_TIMER, 16'hFF20);
        add_chk(64'd7843134, 8'h80, 16'h0100, 16'h00FF, F_KEY, IRQ_KEY, 16'hFF22);
        add_cfg(REG_VECTOR_BASE, 12'h0FF);
        add_chk(64'd7843134, 8'hFE, 16'h0100, 16'h00FF, F_KEY, IRQ_KEY, 16'hFE22);
        add_cfg(REG_VECTOR_BASE, 12'h001);
        add_chk(64'd7843134, 8'h81, 16'h0100, 16'h00FF, F_KEY, IRQ_KEY, 16'h0022);
        add_cfg(REG_TIMER_HZ, 12'd1);
        add_cfg(REG_FRAME_LINES, 12'hFFF);
        add_cfg(REG_IRQ_ENABLES, 12'h010);
        add_chk(64'd8000000, 8'h80, 16'h2000, 16'h3000, 3'b000, PREDICT_ID, '0);
        add_chk(64'd8004069, 8'h80, 16'h2000, 16'h3000, 3'b000, PREDICT_ID, '0);
        add_chk(64'd8004070, 8'h80, 16'h2000, 16'h3000, 3'b000, PREDICT_ID, '0);
        add_cfg(REG_TIMER_HZ, 12'd0);
        add_cfg(REG_FRAME_LINES, 12'd0);
        add_cfg(REG_IRQ_ENABLES, 12'h0FF);
        add_chk(64'd9000000, 8'h7F, 16'h0003, 16'hABCD, F_KEY | F_UART, IRQ_NONE, '0);
        add_chk(64'd9000000, 8'h80, 16'h0003, 16'hABCD, F_KEY | F_UART, IRQ_KEY, 16'h0022);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                settle_block();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else
                send_check(dir_rows[i].chk, dir_rows[i].want_id, dir_rows[i].want_vec);
        end
        clock_ns = 64'd9000000;

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            settle_block();
            if (ph == 0)
            begin
                hz = 8'hFF;
                en = 8'hFF;
                vb = 8'hFF;
                fl = 12'hFFF;
            end
            else if (ph == 1)
            begin
                hz = 8'd1;
                en = 8'h30;
                vb = 8'h00;
                fl = 12'd1;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       hz = 8'd0;
                    1:       hz = 8'd255;
                    default: hz = $urandom_range(1, 255);
                endcase
                en = $urandom_range(0, 255);
                vb = $urandom_range(0, 255);
                case ($urandom_range(0, 3))
                    0:       fl = 12'd0;
                    1:       fl = $urandom_range(1, 8);
                    default: fl = $urandom_range(0, 4095);
                endcase
            end
            write_reg(REG_TIMER_HZ, {4'b0, hz});
            write_reg(REG_IRQ_ENABLES, {4'b0, en});
            write_reg(REG_VECTOR_BASE, {4'b0, vb});
            write_reg(REG_FRAME_LINES, fl);
            tx_max_gap = (ph % 3 == 1) ? 0 : 16;
            rx_max_stall = (ph % 4 == 3) ? 0 : 16;
            hold_req = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // pause the sender until the scoreboard drains
                if (ph == 5 && n % 8 == 7)
                begin
                    s_tvalid = 1'b0;
                    while (pending_xfers.size() != 0) @(negedge clk);
                end
                send_check(random_check(), PREDICT_ID, '0);
            end
        end

        tx_max_gap = 16;
        rx_max_stall = 16;
        settle_block();
        $display("run covered %0d checks and %0d result transfers, %0d long receiver hold-off(s)",
                 checks_sent, xfers_seen, holds_done);
        $display("dispatches: timer %0d, key %0d, uart %0d, vsync %0d, hsync %0d",
                 fired[0], fired[1], fired[2], fired[3], fired[4]);
        if (mismatches == 0)
            $display("tb_priority_interrupt_dispatcher: done, clean");
        else
            $display("tb_priority_interrupt_dispatcher: done, errors");
        $finish;
    end

endmodule
